// ===== hw/rtl/vac_pkg.sv =====
// types and constants shared by the valve actuator controller
// no dependencies
package vac_pkg;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_OPEN      = 3'd1,
    OP_CLOSE     = 3'd2,
    OP_STOP      = 3'd3,
    OP_EMERGENCY = 3'd4,
    OP_CLEAR     = 3'd5
  } op_t;

  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_OPENING = 6'b000010,
    MODE_CLOSING = 6'b000100,
    MODE_OPEN    = 6'b001000,
    MODE_CLOSED  = 6'b010000,
    MODE_FAULT   = 6'b100000
  } mode_t;

  localparam logic [2:0] MODE_CODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_CODE_OPENING = 3'd1;
  localparam logic [2:0] MODE_CODE_CLOSING = 3'd2;
  localparam logic [2:0] MODE_CODE_OPEN    = 3'd3;
  localparam logic [2:0] MODE_CODE_CLOSED  = 3'd4;
  localparam logic [2:0] MODE_CODE_FAULT   = 3'd5;

  typedef enum logic [1:0] {
    DRV_STOP  = 2'd0,
    DRV_OPEN  = 2'd1,
    DRV_CLOSE = 2'd2
  } drive_t;

  localparam int FL_ONLINE  = 0;
  localparam int FL_OPEN    = 1;
  localparam int FL_CLOSED  = 2;
  localparam int FL_MOVING  = 3;
  localparam int FL_FAULT   = 4;
  localparam int FL_OVERCUR = 5;
  localparam int FL_TIMEOUT = 6;
  localparam int FL_STALL   = 7;

  localparam logic [7:0] FLAGS_RESET = 8'h01;

  localparam logic [1:0] CFG_MOVE_TIMEOUT    = 2'd0;
  localparam logic [1:0] CFG_SAMPLE_INTERVAL = 2'd1;
  localparam logic [1:0] CFG_OVERCURRENT     = 2'd2;

  localparam logic [15:0] MOVE_TIMEOUT_RESET    = 16'd30000;
  localparam logic [15:0] SAMPLE_INTERVAL_RESET = 16'd100;
  localparam logic [15:0] OVERCURRENT_RESET     = 16'd2000;

  typedef struct packed {
    logic [2:0]  operation;
    logic        open_switch;
    logic        closed_switch;
    logic [15:0] sensed_current_ma;
  } item_t;

  typedef struct packed {
    logic [2:0]  valve_mode;
    logic [7:0]  status_bits;
    logic [1:0]  motor_drive;
    logic [15:0] held_current_ma;
  } result_t;

  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] c;
    unique case (m)
      MODE_IDLE:    c = MODE_CODE_IDLE;
      MODE_OPENING: c = MODE_CODE_OPENING;
      MODE_CLOSING: c = MODE_CODE_CLOSING;
      MODE_OPEN:    c = MODE_CODE_OPEN;
      MODE_CLOSED:  c = MODE_CODE_CLOSED;
      MODE_FAULT:   c = MODE_CODE_FAULT;
      default:      c = MODE_CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/vac_in_stage.sv =====
// input register of the valve actuator controller
// depends on vac_pkg
module vac_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  vac_pkg::item_t in_item,
  input  logic          advance,
  output logic          item_valid,
  output vac_pkg::item_t item
);
  import vac_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  assign in_stall  = valid_r && !advance;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== hw/rtl/vac_core.sv =====
// valve state, timers, configuration registers and next-state logic
// depends on vac_pkg
module vac_core #(
  parameter int TIMER_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_wdata,
  input  logic             step,
  input  vac_pkg::item_t   item,
  output vac_pkg::result_t result
);
  import vac_pkg::*;

  localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  logic [15:0] timeout_r, interval_r, limit_r;

  mode_t                  mode_r, mode_nxt;
  logic [7:0]             flag_r, flag_nxt;
  logic [TIMER_BITS-1:0]  elapsed_r, elapsed_nxt, elapsed_inc;
  logic [TIMER_BITS-1:0]  since_r, since_nxt, since_inc;
  logic [15:0]            last_r, last_nxt;
  drive_t                 drive_r, drive_nxt;

  logic moving, sample_hit, oc_hit, timeout_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= MOVE_TIMEOUT_RESET;
      interval_r <= SAMPLE_INTERVAL_RESET;
      limit_r    <= OVERCURRENT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MOVE_TIMEOUT:    timeout_r  <= cfg_wdata;
        CFG_SAMPLE_INTERVAL: interval_r <= cfg_wdata;
        CFG_OVERCURRENT:     limit_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign elapsed_inc = (&elapsed_r) ? elapsed_r : elapsed_r + 1'b1;
  assign since_inc   = (&since_r) ? since_r : since_r + 1'b1;
  assign moving      = (mode_r == MODE_OPENING) || (mode_r == MODE_CLOSING);
  assign sample_hit  = moving && (CW'(since_inc) >= CW'(interval_r));
  assign oc_hit      = sample_hit && (item.sensed_current_ma >= limit_r);
  assign timeout_hit = CW'(elapsed_inc) > CW'(timeout_r);

  always_comb begin
    mode_nxt    = mode_r;
    flag_nxt    = flag_r;
    elapsed_nxt = elapsed_r;
    since_nxt   = since_r;
    last_nxt    = last_r;
    drive_nxt   = drive_r;
    unique case (item.operation)
      OP_TICK: begin
        elapsed_nxt = elapsed_inc;
        since_nxt   = since_inc;
        if (sample_hit) begin
          last_nxt  = item.sensed_current_ma;
          since_nxt = '0;
        end
        priority if (oc_hit) begin
          drive_nxt            = DRV_STOP;
          mode_nxt             = MODE_FAULT;
          flag_nxt[FL_FAULT]   = 1'b1;
          flag_nxt[FL_OVERCUR] = 1'b1;
          flag_nxt[FL_MOVING]  = 1'b0;
        end else if ((mode_r == MODE_OPENING && item.open_switch) ||
                     (mode_r == MODE_CLOSING && item.closed_switch)) begin
          drive_nxt           = DRV_STOP;
          flag_nxt[FL_MOVING] = 1'b0;
          if (mode_r == MODE_OPENING) begin
            mode_nxt          = MODE_OPEN;
            flag_nxt[FL_OPEN] = 1'b1;
          end else begin
            mode_nxt            = MODE_CLOSED;
            flag_nxt[FL_CLOSED] = 1'b1;
          end
        end else if (moving && timeout_hit) begin
          drive_nxt            = DRV_STOP;
          mode_nxt             = MODE_FAULT;
          flag_nxt[FL_FAULT]   = 1'b1;
          flag_nxt[FL_TIMEOUT] = 1'b1;
          flag_nxt[FL_MOVING]  = 1'b0;
        end else begin
        end
      end
      OP_OPEN, OP_CLOSE: begin
        if ((item.operation == OP_OPEN && !item.open_switch) ||
            (item.operation == OP_CLOSE && !item.closed_switch)) begin
          mode_nxt = (item.operation == OP_OPEN) ? MODE_OPENING : MODE_CLOSING;
          drive_nxt = (item.operation == OP_OPEN) ? DRV_OPEN : DRV_CLOSE;
          flag_nxt[FL_OPEN]    = 1'b0;
          flag_nxt[FL_CLOSED]  = 1'b0;
          flag_nxt[FL_FAULT]   = 1'b0;
          flag_nxt[FL_OVERCUR] = 1'b0;
          flag_nxt[FL_TIMEOUT] = 1'b0;
          flag_nxt[FL_STALL]   = 1'b0;
          flag_nxt[FL_MOVING]  = 1'b1;
          elapsed_nxt          = '0;
        end
      end
      OP_STOP, OP_CLEAR: begin
        if (item.operation == OP_STOP || mode_r == MODE_FAULT) begin
          if (item.operation == OP_STOP) begin
            drive_nxt           = DRV_STOP;
            flag_nxt[FL_MOVING] = 1'b0;
          end else begin
            flag_nxt[FL_FAULT]   = 1'b0;
            flag_nxt[FL_OVERCUR] = 1'b0;
            flag_nxt[FL_TIMEOUT] = 1'b0;
            flag_nxt[FL_STALL]   = 1'b0;
          end
          // open switch wins when both are pressed
          priority if (item.open_switch) begin
            mode_nxt          = MODE_OPEN;
            flag_nxt[FL_OPEN] = 1'b1;
          end else if (item.closed_switch) begin
            mode_nxt            = MODE_CLOSED;
            flag_nxt[FL_CLOSED] = 1'b1;
          end else begin
            mode_nxt = MODE_IDLE;
          end
        end
      end
      OP_EMERGENCY: begin
        mode_nxt            = MODE_CLOSING;
        drive_nxt           = DRV_CLOSE;
        flag_nxt[FL_OPEN]   = 1'b0;
        flag_nxt[FL_FAULT]  = 1'b0;
        flag_nxt[FL_MOVING] = 1'b1;
        elapsed_nxt         = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      flag_r    <= FLAGS_RESET;
      elapsed_r <= '0;
      since_r   <= '1;
      last_r    <= '0;
      drive_r   <= DRV_STOP;
    end else if (step) begin
      mode_r    <= mode_nxt;
      flag_r    <= flag_nxt;
      elapsed_r <= elapsed_nxt;
      since_r   <= since_nxt;
      last_r    <= last_nxt;
      drive_r   <= drive_nxt;
    end
  end

  assign result.valve_mode      = mode_code(mode_nxt);
  assign result.status_bits     = flag_nxt;
  assign result.motor_drive     = drive_nxt;
  assign result.held_current_ma = last_nxt;

endmodule

// ===== hw/rtl/valve_actuator_controller.sv =====
// valve actuator controller: input register, state update, result register
// path: an item passes the input register, then the state update, then the result register
// throughput: one item per cycle while out_stall is low; out_stall holds both stages
// reset: synchronous active-low rst_n empties both stages and restores state
// and configuration to their power-up values
// depends on vac_pkg, vac_in_stage, vac_core
module valve_actuator_controller #(
  parameter int TIMER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic        in_open_switch,
  input  logic        in_closed_switch,
  input  logic [15:0] in_sensed_current_ma,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_valve_mode,
  output logic [7:0]  out_status_bits,
  output logic [1:0]  out_motor_drive,
  output logic [15:0] out_held_current_ma
);
  import vac_pkg::*;

  item_t   in_item, item;
  result_t result, result_r;
  logic    item_valid, advance, step;
  logic    out_valid_r, out_valid_nxt;

  assign in_item.operation         = op_t'(in_operation);
  assign in_item.open_switch       = in_open_switch;
  assign in_item.closed_switch     = in_closed_switch;
  assign in_item.sensed_current_ma = in_sensed_current_ma;

  // result register free or its transfer completes this cycle
  assign advance = !out_valid_r || !out_stall;
  assign step    = item_valid && advance;

  vac_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  vac_core #(.TIMER_BITS(TIMER_BITS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (item),
    .result    (result)
  );

  assign out_valid_nxt = step ? 1'b1 : (advance ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_r <= result;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_valve_mode      = result_r.valve_mode;
  assign out_status_bits     = result_r.status_bits;
  assign out_motor_drive     = result_r.motor_drive;
  assign out_held_current_ma = result_r.held_current_ma;

endmodule

// ===== hw/rtl/vac_checker.sv =====
// port-level assertions for the valve actuator controller
// bound to valve_actuator_controller, depends on vac_pkg
module vac_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_we,
  input logic [1:0]  cfg_index,
  input logic [15:0] cfg_wdata,
  input logic        in_valid,
  input logic        in_stall,
  input logic [2:0]  in_operation,
  input logic        in_open_switch,
  input logic        in_closed_switch,
  input logic [15:0] in_sensed_current_ma,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_valve_mode,
  input logic [7:0]  out_status_bits,
  input logic [1:0]  out_motor_drive,
  input logic [15:0] out_held_current_ma
);
  import vac_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_valve_mode) &&
      $stable(out_status_bits) && $stable(out_motor_drive) &&
      $stable(out_held_current_ma))
    else $error("stalled result changed");

  // motor runs only while moving is flagged
  a_drive_moving: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_motor_drive != DRV_STOP |-> out_status_bits[FL_MOVING])
    else $error("motor driven without moving flag");

  // fault mode always has the motor stopped and the fault flag set
  a_fault_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valve_mode == MODE_CODE_FAULT |-> out_motor_drive == DRV_STOP &&
      out_status_bits[FL_FAULT])
    else $error("fault mode with motor running or flag clear");

  // online always set, stall never set
  a_flags_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status_bits[FL_ONLINE] && !out_status_bits[FL_STALL])
    else $error("online or stall flag wrong");

endmodule

bind valve_actuator_controller vac_checker u_vac_checker (.*);
